// File: rtl/frs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frs_pkg
// shared sizes, codes, types and stage decode for the flash resource
// scoreboard
// ----------------------------------------------------------------------------
package frs_pkg;

   // resource geometry
   localparam int CHANNELS   = 8;
   localparam int CH_CHIPS   = 4;
   localparam int CHIP_DIES  = 2;
   localparam int DIE_PLANES = 2;
   localparam int ID_BITS    = 9;

   localparam int NUM_CHIPS  = CHANNELS * CH_CHIPS;
   localparam int NUM_CORES  = NUM_CHIPS * CHIP_DIES;
   localparam int NUM_PLANES = NUM_CORES * DIE_PLANES;

   // table index widths
   localparam int CHAN_IW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CHIP_IW  = (NUM_CHIPS > 1) ? $clog2(NUM_CHIPS) : 1;
   localparam int CORE_IW  = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
   localparam int PLANE_IW = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

   // port field widths
   localparam int IDX_W     = 2;
   localparam int CH_W      = 3;
   localparam int CP_W      = 2;
   localparam int DIE_W     = 1;
   localparam int PL_W      = 1;
   localparam int CMD_ID_W  = 9;
   localparam int STATUS_W  = 2;
   localparam int STAGE_W   = 3;
   localparam int DUR_W     = 20;
   localparam int CSR_IDX_W = 3;

   // request kinds
   localparam logic KIND_ISSUE    = 1'b0;
   localparam logic KIND_COMPLETE = 1'b1;

   // opcodes
   localparam logic OP_READ_COMPUTE = 1'b0;
   localparam logic OP_READ_SLICE   = 1'b1;

   // response status codes
   localparam logic [STATUS_W-1:0] RSP_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] RSP_BUSY    = 2'd1;
   localparam logic [STATUS_W-1:0] RSP_INVALID = 2'd2;

   // stage codes
   localparam logic [STAGE_W-1:0] STG_CA  = 3'd0;
   localparam logic [STAGE_W-1:0] STG_VEC = 3'd1;
   localparam logic [STAGE_W-1:0] STG_ARR = 3'd2;
   localparam logic [STAGE_W-1:0] STG_CMP = 3'd3;
   localparam logic [STAGE_W-1:0] STG_DAT = 3'd4;

   // stage counts per opcode
   localparam int RC_STAGES = 4;
   localparam int RS_STAGES = 2;

   // csr register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CA_CYCLES      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VECTOR_CYCLES  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ARRAY_CYCLES   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COMPUTE_CYCLES = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_CYCLES    = 3'd4;

   // csr reset values
   localparam logic [DUR_W-1:0] CA_CYCLES_RST      = 20'd7;
   localparam logic [DUR_W-1:0] VECTOR_CYCLES_RST  = 20'd256;
   localparam logic [DUR_W-1:0] ARRAY_CYCLES_RST   = 20'd30000;
   localparam logic [DUR_W-1:0] COMPUTE_CYCLES_RST = 20'd1024;
   localparam logic [DUR_W-1:0] DATA_CYCLES_RST    = 20'd4096;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic commit;
   } frs_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic out_hold;
   } frs_sts_type;

   // number of stages of an opcode
   function automatic logic [STAGE_W-1:0] op_stage_total(input logic op);
      return (op == OP_READ_COMPUTE) ? STAGE_W'(RC_STAGES) : STAGE_W'(RS_STAGES);
   endfunction

   // stage code from opcode and stage index
   function automatic logic [STAGE_W-1:0] decode_stage(input logic op,
                                                       input logic [IDX_W-1:0] idx);
      logic [STAGE_W-1:0] s;
      s = STG_CA;
      if (op == OP_READ_COMPUTE) begin
         case (idx)
            2'd0:    s = STG_CA;
            2'd1:    s = STG_VEC;
            2'd2:    s = STG_ARR;
            default: s = STG_CMP;
         endcase
      end else begin
         s = (idx == '0) ? STG_CA : STG_DAT;
      end
      return s;
   endfunction

endpackage
`default_nettype wire

// File: rtl/frs_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frs_ctrl
// two-state sequencer: take a request, then decide and commit it once the
// response register can take the result
// ----------------------------------------------------------------------------
module frs_ctrl
   import frs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire frs_sts_type sts,
   output frs_cmd_type      cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff;
   logic state_in;

   // command decode
   always_comb begin
      cmd.load   = 1'b0;
      cmd.commit = 1'b0;
      state_in   = state_ff;
      req_stall  = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (!sts.out_hold) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTH
   a_load_to_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_EXEC)
      else $error("request taken but sequencer not in exec");

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !sts.out_hold)
      else $error("commit while response register held");

   a_exec_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && sts.out_hold) |=> state_ff == S_EXEC)
      else $error("exec left while response register held");
`endif

endmodule
`default_nettype wire

// File: rtl/frs_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frs_datapath
// owner tables, stage decode, grant and release decision, duration registers
// and the response register
// ----------------------------------------------------------------------------
module frs_datapath
   import frs_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire frs_cmd_type          cmd,
   output frs_sts_type               sts,
   input  wire logic                 req_kind,
   input  wire logic                 req_opcode,
   input  wire logic [IDX_W-1:0]     req_stage_idx,
   input  wire logic [CH_W-1:0]      req_channel,
   input  wire logic [CP_W-1:0]      req_chip,
   input  wire logic [DIE_W-1:0]     req_die,
   input  wire logic [PL_W-1:0]      req_plane,
   input  wire logic [CMD_ID_W-1:0]  req_cmd_id,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DUR_W-1:0]     csr_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [STAGE_W-1:0]        rsp_stage,
   output logic [DUR_W-1:0]          rsp_duration,
   output logic [STAGE_W-1:0]        rsp_next_idx,
   output logic                      rsp_command_done
);

   // duration registers
   logic [DUR_W-1:0] ca_cycles_ff;
   logic [DUR_W-1:0] vector_cycles_ff;
   logic [DUR_W-1:0] array_cycles_ff;
   logic [DUR_W-1:0] compute_cycles_ff;
   logic [DUR_W-1:0] data_cycles_ff;

   // owner tables: valid bits in flops, ids in flops or ram
   logic [CHANNELS-1:0]   chan_vld_ff;
   logic [NUM_CHIPS-1:0]  chip_vld_ff;
   logic [NUM_CORES-1:0]  core_vld_ff;
   logic [NUM_PLANES-1:0] plane_vld_ff;
   logic [ID_BITS-1:0]    chan_id_ff [CHANNELS];
   logic [ID_BITS-1:0]    chip_id_ff [NUM_CHIPS];
   logic [ID_BITS-1:0]    core_id_mem [NUM_CORES];
   logic [ID_BITS-1:0]    plane_id_mem [NUM_PLANES];

   // latched request
   logic                 kind_ff;
   logic                 op_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic [ID_BITS-1:0]   id_ff;
   logic                 in_range_ff;
   logic [CHAN_IW-1:0]   ch_ix_ff;
   logic [CHIP_IW-1:0]   ci_ff;
   logic [CORE_IW-1:0]   ki_ff;
   logic [PLANE_IW-1:0]  pi_ff;

   // latched table reads
   logic                 chan_vld_rd_ff;
   logic                 chip_vld_rd_ff;
   logic                 core_vld_rd_ff;
   logic                 plane_vld_rd_ff;
   logic [ID_BITS-1:0]   chan_id_rd_ff;
   logic [ID_BITS-1:0]   chip_id_rd_ff;
   logic [ID_BITS-1:0]   core_id_rd_ff;
   logic [ID_BITS-1:0]   plane_id_rd_ff;

   // response register
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [STATUS_W-1:0]  rsp_status_in;
   logic [STAGE_W-1:0]   rsp_stage_ff;
   logic [STAGE_W-1:0]   rsp_stage_in;
   logic [DUR_W-1:0]     rsp_duration_ff;
   logic [DUR_W-1:0]     rsp_duration_in;
   logic [STAGE_W-1:0]   rsp_next_ff;
   logic [STAGE_W-1:0]   rsp_next_in;
   logic                 rsp_done_ff;
   logic                 rsp_done_in;

   // request side index math
   logic                 in_range_in;
   int                   ci_full;
   int                   ki_full;
   int                   pi_full;
   logic [CHAN_IW-1:0]   ch_ix_in;
   logic [CHIP_IW-1:0]   ci_in;
   logic [CORE_IW-1:0]   ki_in;
   logic [PLANE_IW-1:0]  pi_in;

   // decision signals
   logic [STAGE_W-1:0]   stage_w;
   logic [STAGE_W-1:0]   count_w;
   logic [STAGE_W-1:0]   next_w;
   logic                 invalid_w;
   logic                 xfer_w;
   logic                 is_issue_w;
   logic                 grant_ok_w;
   logic                 do_grant;
   logic                 do_release;
   logic                 set_chan;
   logic                 set_plane;
   logic                 set_core;
   logic                 rel_chan;
   logic                 rel_chip;
   logic                 rel_core;
   logic                 rel_plane;
   logic [DUR_W-1:0]     dur_w;

   assign csr_ready = 1'b1;

   // csr writes, unknown indexes dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         ca_cycles_ff      <= CA_CYCLES_RST;
         vector_cycles_ff  <= VECTOR_CYCLES_RST;
         array_cycles_ff   <= ARRAY_CYCLES_RST;
         compute_cycles_ff <= COMPUTE_CYCLES_RST;
         data_cycles_ff    <= DATA_CYCLES_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CA_CYCLES:      ca_cycles_ff      <= csr_data;
            CSR_VECTOR_CYCLES:  vector_cycles_ff  <= csr_data;
            CSR_ARRAY_CYCLES:   array_cycles_ff   <= csr_data;
            CSR_COMPUTE_CYCLES: compute_cycles_ff <= csr_data;
            CSR_DATA_CYCLES:    data_cycles_ff    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // flat table indexes from the target address
   always_comb begin
      in_range_in = (int'(req_channel) < CHANNELS) &&
                    (int'(req_chip) < CH_CHIPS) &&
                    (int'(req_die) < CHIP_DIES) &&
                    (int'(req_plane) < DIE_PLANES);
      ci_full = int'(req_channel) * CH_CHIPS + int'(req_chip);
      ki_full = ci_full * CHIP_DIES + int'(req_die);
      pi_full = ki_full * DIE_PLANES + int'(req_plane);
      ch_ix_in = in_range_in ? CHAN_IW'(req_channel) : '0;
      ci_in    = in_range_in ? CHIP_IW'(ci_full) : '0;
      ki_in    = in_range_in ? CORE_IW'(ki_full) : '0;
      pi_in    = in_range_in ? PLANE_IW'(pi_full) : '0;
   end

   // latch request and read the owner tables
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff         <= req_kind;
         op_ff           <= req_opcode;
         idx_ff          <= req_stage_idx;
         id_ff           <= ID_BITS'(req_cmd_id);
         in_range_ff     <= in_range_in;
         ch_ix_ff        <= ch_ix_in;
         ci_ff           <= ci_in;
         ki_ff           <= ki_in;
         pi_ff           <= pi_in;
         chan_vld_rd_ff  <= chan_vld_ff[ch_ix_in];
         chip_vld_rd_ff  <= chip_vld_ff[ci_in];
         core_vld_rd_ff  <= core_vld_ff[ki_in];
         plane_vld_rd_ff <= plane_vld_ff[pi_in];
         chan_id_rd_ff   <= chan_id_ff[ch_ix_in];
         chip_id_rd_ff   <= chip_id_ff[ci_in];
      end
   end

   // owner id rams, registered read on load
   always_ff @(posedge clock) begin
      if (set_core) begin
         core_id_mem[ki_ff] <= id_ff;
      end
      if (cmd.load) begin
         core_id_rd_ff <= core_id_mem[ki_in];
      end
   end

   always_ff @(posedge clock) begin
      if (set_plane) begin
         plane_id_mem[pi_ff] <= id_ff;
      end
      if (cmd.load) begin
         plane_id_rd_ff <= plane_id_mem[pi_in];
      end
   end

   // stage decode and grant check
   always_comb begin
      stage_w    = decode_stage(op_ff, idx_ff);
      count_w    = op_stage_total(op_ff);
      next_w     = {1'b0, idx_ff} + STAGE_W'(1);
      invalid_w  = {1'b0, idx_ff} >= count_w;
      xfer_w     = (stage_w == STG_CA) || (stage_w == STG_VEC) || (stage_w == STG_DAT);
      is_issue_w = kind_ff == KIND_ISSUE;
      grant_ok_w = in_range_ff && !chip_vld_rd_ff &&
                   (xfer_w ? !chan_vld_rd_ff
                           : (!plane_vld_rd_ff &&
                              ((stage_w != STG_CMP) || !core_vld_rd_ff)));
      do_grant   = cmd.commit && !invalid_w && is_issue_w && grant_ok_w;
      do_release = cmd.commit && !invalid_w && !is_issue_w && in_range_ff;
      set_chan   = do_grant && xfer_w;
      set_plane  = do_grant && !xfer_w;
      set_core   = do_grant && (stage_w == STG_CMP);
      rel_chan   = do_release && chan_vld_rd_ff && (chan_id_rd_ff == id_ff);
      rel_chip   = do_release && chip_vld_rd_ff && (chip_id_rd_ff == id_ff);
      rel_core   = do_release && core_vld_rd_ff && (core_id_rd_ff == id_ff);
      rel_plane  = do_release && plane_vld_rd_ff && (plane_id_rd_ff == id_ff);
   end

   // valid bits: set on grant, cleared on release by the owner
   always_ff @(posedge clock) begin
      if (reset) begin
         chan_vld_ff  <= '0;
         chip_vld_ff  <= '0;
         core_vld_ff  <= '0;
         plane_vld_ff <= '0;
      end else begin
         if (set_chan) begin
            chan_vld_ff[ch_ix_ff] <= 1'b1;
         end else if (rel_chan) begin
            chan_vld_ff[ch_ix_ff] <= 1'b0;
         end
         if (do_grant) begin
            chip_vld_ff[ci_ff] <= 1'b1;
         end else if (rel_chip) begin
            chip_vld_ff[ci_ff] <= 1'b0;
         end
         if (set_core) begin
            core_vld_ff[ki_ff] <= 1'b1;
         end else if (rel_core) begin
            core_vld_ff[ki_ff] <= 1'b0;
         end
         if (set_plane) begin
            plane_vld_ff[pi_ff] <= 1'b1;
         end else if (rel_plane) begin
            plane_vld_ff[pi_ff] <= 1'b0;
         end
      end
   end

   // channel and chip owner ids
   always_ff @(posedge clock) begin
      if (set_chan) begin
         chan_id_ff[ch_ix_ff] <= id_ff;
      end
      if (do_grant) begin
         chip_id_ff[ci_ff] <= id_ff;
      end
   end

   // duration of the stage
   always_comb begin
      case (stage_w)
         STG_CA:  dur_w = ca_cycles_ff;
         STG_VEC: dur_w = vector_cycles_ff;
         STG_ARR: dur_w = array_cycles_ff;
         STG_CMP: dur_w = compute_cycles_ff;
         default: dur_w = data_cycles_ff;
      endcase
   end

   // response fields
   always_comb begin
      rsp_status_in   = RSP_OK;
      rsp_stage_in    = STG_CA;
      rsp_duration_in = '0;
      rsp_next_in     = '0;
      rsp_done_in     = 1'b0;
      if (invalid_w) begin
         rsp_status_in = RSP_INVALID;
      end else begin
         rsp_stage_in = stage_w;
         if (!is_issue_w) begin
            rsp_next_in = next_w;
            rsp_done_in = next_w >= count_w;
         end else if (grant_ok_w) begin
            rsp_duration_in = dur_w;
         end else begin
            rsp_status_in = RSP_BUSY;
         end
      end
   end

   // response register
   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status_ff   <= rsp_status_in;
         rsp_stage_ff    <= rsp_stage_in;
         rsp_duration_ff <= rsp_duration_in;
         rsp_next_ff     <= rsp_next_in;
         rsp_done_ff     <= rsp_done_in;
      end
   end

   assign sts.out_hold     = rsp_valid_ff && rsp_stall;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_stage        = rsp_stage_ff;
   assign rsp_duration     = rsp_duration_ff;
   assign rsp_next_idx     = rsp_next_ff;
   assign rsp_command_done = rsp_done_ff;

`ifndef SYNTH
   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("committed request left no response");

   a_grant_owns_chip: assert property (@(posedge clock) disable iff (reset)
      do_grant |=> chip_vld_ff[ci_ff])
      else $error("granted chip not marked owned");

   a_release_frees_chip: assert property (@(posedge clock) disable iff (reset)
      rel_chip |=> !chip_vld_ff[ci_ff])
      else $error("released chip still owned");

   a_invalid_no_grant: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && invalid_w) |=>
         (rsp_status_ff == RSP_INVALID) && (rsp_duration_ff == '0))
      else $error("invalid stage produced a grant");
`endif

endmodule
`default_nettype wire

// File: rtl/flash_resource_scoreboard.sv
`default_nettype none
// ----------------------------------------------------------------------------
// flash_resource_scoreboard
// tracks channel, chip, plane and compute-core ownership of flash commands
// ----------------------------------------------------------------------------
// Each request is handled in two steps. In the accept step the target address
// is turned into table indexes and the owner tables are read (plane and core
// owner ids sit in RAMs with a registered read port). In the commit step the
// grant or release is decided, the tables are written and the response
// register is loaded; commit waits while a response is held by rsp_stall.
// A new request is taken only once the previous one has been committed.
// All owner valid bits are flops cleared by reset, so
// the block is ready right after reset with no clearing pass. Duration
// registers are written through the csr port, which is always ready.
module flash_resource_scoreboard
   import frs_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_kind,
   input  wire logic                 req_opcode,
   input  wire logic [IDX_W-1:0]     req_stage_idx,
   input  wire logic [CH_W-1:0]      req_channel,
   input  wire logic [CP_W-1:0]      req_chip,
   input  wire logic [DIE_W-1:0]     req_die,
   input  wire logic [PL_W-1:0]      req_plane,
   input  wire logic [CMD_ID_W-1:0]  req_cmd_id,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [STAGE_W-1:0]        rsp_stage,
   output logic [DUR_W-1:0]          rsp_duration,
   output logic [STAGE_W-1:0]        rsp_next_idx,
   output logic                      rsp_command_done,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DUR_W-1:0]     csr_data
);

   frs_cmd_type cmd;
   frs_sts_type sts;

   // sequencer
   frs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // tables and response path
   frs_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_kind         (req_kind),
      .req_opcode       (req_opcode),
      .req_stage_idx    (req_stage_idx),
      .req_channel      (req_channel),
      .req_chip         (req_chip),
      .req_die          (req_die),
      .req_plane        (req_plane),
      .req_cmd_id       (req_cmd_id),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_stage        (rsp_stage),
      .rsp_duration     (rsp_duration),
      .rsp_next_idx     (rsp_next_idx),
      .rsp_command_done (rsp_command_done)
   );

endmodule
`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// checks the flash resource scoreboard against a cycle-free prediction of
// its owner tables: a directed opening, then interleaved stage sequences of
// several commands on a few hot channels and chips, mixed with random
// requests, under several duration settings and random stalls on both sides
// ----------------------------------------------------------------------------
module tb_top
   import frs_pkg::*;
();

   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 300;
   localparam int MAX_REPORTS    = 50;

   // one request as it crosses the req_ port
   typedef struct packed {
      logic                kind;
      logic                opcode;
      logic [IDX_W-1:0]    stage_idx;
      logic [CH_W-1:0]     channel;
      logic [CP_W-1:0]     chip;
      logic [DIE_W-1:0]    die;
      logic [PL_W-1:0]     plane;
      logic [CMD_ID_W-1:0] cmd_id;
   } flash_req_type;

   localparam int REQ_W = $bits(flash_req_type);

   // one response as it crosses the rsp_ port
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [STAGE_W-1:0]  stage;
      logic [DUR_W-1:0]    duration;
      logic [STAGE_W-1:0]  next_idx;
      logic                command_done;
   } flash_rsp_type;

   // owner table entry
   typedef struct packed {
      logic               owned;
      logic [ID_BITS-1:0] id;
   } owner_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_kind = 1'b0;
   logic                 req_opcode = 1'b0;
   logic [IDX_W-1:0]     req_stage_idx = '0;
   logic [CH_W-1:0]      req_channel = '0;
   logic [CP_W-1:0]      req_chip = '0;
   logic [DIE_W-1:0]     req_die = '0;
   logic [PL_W-1:0]      req_plane = '0;
   logic [CMD_ID_W-1:0]  req_cmd_id = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic [STAGE_W-1:0]   rsp_stage;
   logic [DUR_W-1:0]     rsp_duration;
   logic [STAGE_W-1:0]   rsp_next_idx;
   logic                 rsp_command_done;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DUR_W-1:0]     csr_data = '0;

   // predicted block state
   owner_type        channel_owner [CHANNELS];
   owner_type        chip_owner [NUM_CHIPS];
   owner_type        plane_owner [NUM_PLANES];
   owner_type        core_owner [NUM_CORES];
   logic [DUR_W-1:0] duration_reg [0:4];

   flash_req_type pending_reqs [$];
   flash_rsp_type expected_rsps [$];
   int            queued_count = 0;
   int            accepted_count = 0;
   int            checked_count = 0;
   int            error_count = 0;
   int            quiet_cycles = 0;
   bit            idling = 1'b1;
   int            gap_left = 0;
   int            stall_left = 0;
   int            hold_left = 0;
   int            hold_requests = 0;
   int            holds_served = 0;

   flash_resource_scoreboard dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_opcode       (req_opcode),
      .req_stage_idx    (req_stage_idx),
      .req_channel      (req_channel),
      .req_chip         (req_chip),
      .req_die          (req_die),
      .req_plane        (req_plane),
      .req_cmd_id       (req_cmd_id),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_stage        (rsp_stage),
      .rsp_duration     (rsp_duration),
      .rsp_next_idx     (rsp_next_idx),
      .rsp_command_done (rsp_command_done),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // entry freed only when the completing id owns it
   function automatic owner_type drop_owner(input owner_type e,
                                            input logic [ID_BITS-1:0] id);
      return (e.owned && e.id == id) ? owner_type'('0) : e;
   endfunction

   // grant, busy or release decision for one request, updating the tables
   function automatic flash_rsp_type resolve_request(input flash_req_type r);
      flash_rsp_type      rsp;
      int                 n_stages, ci, ki, pi;
      logic [STAGE_W-1:0] stg;
      logic               xfer, granted;
      owner_type          tag;
      rsp = '0;
      n_stages = (r.opcode == OP_READ_COMPUTE) ? RC_STAGES : RS_STAGES;
      // index past the last stage leaves everything alone
      if (int'(r.stage_idx) >= n_stages) begin
         rsp.status = RSP_INVALID;
         return rsp;
      end
      if (r.opcode == OP_READ_SLICE) begin
         stg = (r.stage_idx == '0) ? STG_CA : STG_DAT;
      end else begin
         case (r.stage_idx)
            2'd0:    stg = STG_CA;
            2'd1:    stg = STG_VEC;
            2'd2:    stg = STG_ARR;
            default: stg = STG_CMP;
         endcase
      end
      rsp.stage = stg;
      // port widths match the geometry, so every target is in range
      ci = int'(r.channel) * CH_CHIPS + int'(r.chip);
      ki = ci * CHIP_DIES + int'(r.die);
      pi = ki * DIE_PLANES + int'(r.plane);

      // complete: free whatever this id still holds at the target
      if (r.kind == KIND_COMPLETE) begin
         channel_owner[r.channel] = drop_owner(channel_owner[r.channel], r.cmd_id);
         chip_owner[ci] = drop_owner(chip_owner[ci], r.cmd_id);
         plane_owner[pi] = drop_owner(plane_owner[pi], r.cmd_id);
         core_owner[ki] = drop_owner(core_owner[ki], r.cmd_id);
         rsp.status = RSP_OK;
         rsp.next_idx = STAGE_W'(r.stage_idx) + 1'b1;
         rsp.command_done = (int'(r.stage_idx) + 1 >= n_stages);
         return rsp;
      end

      // issue: all resources of the stage must be free
      xfer = (stg == STG_CA) || (stg == STG_VEC) || (stg == STG_DAT);
      if (xfer)
         granted = !channel_owner[r.channel].owned && !chip_owner[ci].owned;
      else if (stg == STG_ARR)
         granted = !chip_owner[ci].owned && !plane_owner[pi].owned;
      else
         granted = !chip_owner[ci].owned && !plane_owner[pi].owned &&
                   !core_owner[ki].owned;
      if (!granted) begin
         rsp.status = RSP_BUSY;
         return rsp;
      end
      tag.owned = 1'b1;
      tag.id = r.cmd_id;
      chip_owner[ci] = tag;
      if (xfer) begin
         channel_owner[r.channel] = tag;
      end else begin
         plane_owner[pi] = tag;
         if (stg == STG_CMP) core_owner[ki] = tag;
      end
      case (stg)
         STG_CA:  rsp.duration = duration_reg[CSR_CA_CYCLES];
         STG_VEC: rsp.duration = duration_reg[CSR_VECTOR_CYCLES];
         STG_ARR: rsp.duration = duration_reg[CSR_ARRAY_CYCLES];
         STG_CMP: rsp.duration = duration_reg[CSR_COMPUTE_CYCLES];
         default: rsp.duration = duration_reg[CSR_DATA_CYCLES];
      endcase
      rsp.status = RSP_OK;
      return rsp;
   endfunction

   // mismatch report
   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("mismatch on response %0d at %0t: %s got %0d expected %0d",
                  checked_count, $time, what, got, want);
   endtask

   task automatic queue_request(input flash_req_type r);
      pending_reqs = {pending_reqs, r};
      queued_count++;
   endtask

   // new command at stage 0, mostly on a few hot channels and chips
   function automatic flash_req_type fresh_command();
      flash_req_type c;
      c.kind = KIND_ISSUE;
      c.opcode = $urandom_range(0, 1) ? OP_READ_SLICE : OP_READ_COMPUTE;
      c.stage_idx = '0;
      c.channel = ($urandom_range(0, 9) < 6) ? CH_W'($urandom_range(0, 1))
                                             : CH_W'($urandom_range(0, CHANNELS - 1));
      c.chip = ($urandom_range(0, 9) < 6) ? CP_W'($urandom_range(0, 1))
                                          : CP_W'($urandom_range(0, CH_CHIPS - 1));
      c.die = DIE_W'($urandom_range(0, 1));
      c.plane = PL_W'($urandom_range(0, 1));
      c.cmd_id = CMD_ID_W'($urandom);
      return c;
   endfunction

   // interleaved issue/complete sequences of four commands plus random noise
   task automatic queue_random_traffic(input int n_items);
      flash_req_type active [4];
      int            progress [4];
      flash_req_type cleanup [$];
      flash_req_type r;
      int            slot, n_stages;
      for (int s = 0; s < 4; s++) begin
         active[s] = fresh_command();
         progress[s] = 0;
      end
      for (int n = 0; n < n_items; n++) begin
         if (cleanup.size() != 0 && $urandom_range(0, 3) == 0) begin
            queue_request(cleanup.pop_front());
         end else if ($urandom_range(0, 9) == 0) begin
            // any field combination; a later complete frees what it may grab
            r = REQ_W'($urandom);
            queue_request(r);
            if (r.kind == KIND_ISSUE) begin
               r.kind = KIND_COMPLETE;
               cleanup = {cleanup, r};
            end
         end else begin
            slot = $urandom_range(0, 3);
            r = active[slot];
            r.stage_idx = IDX_W'(progress[slot] / 2);
            r.kind = (progress[slot] % 2 == 1) ? KIND_COMPLETE : KIND_ISSUE;
            queue_request(r);
            // an issue is now and then retried before its complete
            if (r.kind == KIND_COMPLETE || $urandom_range(0, 7) != 0) progress[slot]++;
            n_stages = (r.opcode == OP_READ_COMPUTE) ? RC_STAGES : RS_STAGES;
            if (progress[slot] == 2 * n_stages) begin
               active[slot] = fresh_command();
               progress[slot] = 0;
            end
         end
      end
      while (cleanup.size() != 0) queue_request(cleanup.pop_front());
   endtask

   // one register write, mirrored into the prediction
   task automatic write_duration(input logic [CSR_IDX_W-1:0] idx, input logic [DUR_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      duration_reg[idx] = val;
   endtask

   task automatic load_durations(input logic [DUR_W-1:0] ca, input logic [DUR_W-1:0] vec,
                                 input logic [DUR_W-1:0] arr, input logic [DUR_W-1:0] cmp,
                                 input logic [DUR_W-1:0] dat);
      write_duration(CSR_CA_CYCLES, ca);
      write_duration(CSR_VECTOR_CYCLES, vec);
      write_duration(CSR_ARRAY_CYCLES, arr);
      write_duration(CSR_COMPUTE_CYCLES, cmp);
      write_duration(CSR_DATA_CYCLES, dat);
   endtask

   // every queued request accepted and answered, then let the pipe settle
   task automatic wait_drained();
      while (accepted_count != queued_count || expected_rsps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin : driver
      flash_req_type nxt;
      flash_req_type seen;
      flash_rsp_type pred;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // accepted request: predict its response
         if (req_valid && !req_stall) begin
            seen = {req_kind, req_opcode, req_stage_idx, req_channel, req_chip,
                    req_die, req_plane, req_cmd_id};
            pred = resolve_request(seen);
            expected_rsps = {expected_rsps, pred};
            accepted_count++;
         end
         // bus free: idle burst or next request
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (idling && $urandom_range(0, 99) < 15) begin
               gap_left = $urandom_range(0, 2);
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               nxt = pending_reqs.pop_front();
               req_kind <= nxt.kind;
               req_opcode <= nxt.opcode;
               req_stage_idx <= nxt.stage_idx;
               req_channel <= nxt.channel;
               req_chip <= nxt.chip;
               req_die <= nxt.die;
               req_plane <= nxt.plane;
               req_cmd_id <= nxt.cmd_id;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response stall: long hold on request, else short random bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (idling && $urandom_range(0, 99) < 20) begin
            stall_left = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin : monitor
      flash_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         checked_count++;
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected response, status", rsp_status, 0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_stage !== want.stage)
               report_mismatch("stage", rsp_stage, want.stage);
            if (rsp_duration !== want.duration)
               report_mismatch("duration", rsp_duration, want.duration);
            if (rsp_next_idx !== want.next_idx)
               report_mismatch("next stage", rsp_next_idx, want.next_idx);
            if (rsp_command_done !== want.command_done)
               report_mismatch("command done", rsp_command_done, want.command_done);
         end
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles at %0t", quiet_cycles, $time);
         $display("flash_resource_scoreboard test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stimulus sequence
   initial begin
      foreach (channel_owner[i]) channel_owner[i] = '0;
      foreach (chip_owner[i]) chip_owner[i] = '0;
      foreach (plane_owner[i]) plane_owner[i] = '0;
      foreach (core_owner[i]) core_owner[i] = '0;
      duration_reg[CSR_CA_CYCLES] = CA_CYCLES_RST;
      duration_reg[CSR_VECTOR_CYCLES] = VECTOR_CYCLES_RST;
      duration_reg[CSR_ARRAY_CYCLES] = ARRAY_CYCLES_RST;
      duration_reg[CSR_COMPUTE_CYCLES] = COMPUTE_CYCLES_RST;
      duration_reg[CSR_DATA_CYCLES] = DATA_CYCLES_RST;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: reset durations, every stage, busy, foreign complete, bad index
      queue_request('{KIND_ISSUE, OP_READ_COMPUTE, 2'd0, 3'd7, 2'd3, 1'b1, 1'b1, 9'd511});
      queue_request('{KIND_ISSUE, OP_READ_COMPUTE, 2'd0, 3'd7, 2'd3, 1'b1, 1'b1, 9'd5});
      queue_request('{KIND_COMPLETE, OP_READ_COMPUTE, 2'd0, 3'd7, 2'd3, 1'b1, 1'b1, 9'd5});
      queue_request('{KIND_ISSUE, OP_READ_COMPUTE, 2'd0, 3'd7, 2'd3, 1'b0, 1'b0, 9'd5});
      queue_request('{KIND_COMPLETE, OP_READ_COMPUTE, 2'd0, 3'd7, 2'd3, 1'b1, 1'b1, 9'd511});
      queue_request('{KIND_ISSUE, OP_READ_COMPUTE, 2'd1, 3'd7, 2'd3, 1'b1, 1'b1, 9'd511});
      queue_request('{KIND_COMPLETE, OP_READ_COMPUTE, 2'd1, 3'd7, 2'd3, 1'b1, 1'b1, 9'd511});
      queue_request('{KIND_ISSUE, OP_READ_COMPUTE, 2'd2, 3'd0, 2'd0, 1'b0, 1'b0, 9'd511});
      queue_request('{KIND_ISSUE, OP_READ_SLICE, 2'd0, 3'd0, 2'd0, 1'b1, 1'b1, 9'd3});
      queue_request('{KIND_ISSUE, OP_READ_COMPUTE, 2'd2, 3'd0, 2'd1, 1'b0, 1'b0, 9'd4});
      queue_request('{KIND_COMPLETE, OP_READ_COMPUTE, 2'd2, 3'd0, 2'd0, 1'b0, 1'b0, 9'd511});
      queue_request('{KIND_ISSUE, OP_READ_COMPUTE, 2'd3, 3'd0, 2'd0, 1'b0, 1'b0, 9'd511});
      queue_request('{KIND_ISSUE, OP_READ_COMPUTE, 2'd3, 3'd0, 2'd0, 1'b0, 1'b1, 9'd6});
      queue_request('{KIND_COMPLETE, OP_READ_COMPUTE, 2'd3, 3'd0, 2'd0, 1'b0, 1'b0, 9'd511});
      queue_request('{KIND_ISSUE, OP_READ_SLICE, 2'd1, 3'd1, 2'd2, 1'b0, 1'b1, 9'd9});
      queue_request('{KIND_COMPLETE, OP_READ_SLICE, 2'd1, 3'd1, 2'd2, 1'b0, 1'b1, 9'd9});
      queue_request('{KIND_ISSUE, OP_READ_SLICE, 2'd2, 3'd2, 2'd1, 1'b0, 1'b0, 9'd10});
      queue_request('{KIND_COMPLETE, OP_READ_SLICE, 2'd3, 3'd2, 2'd1, 1'b0, 1'b0, 9'd10});
      queue_request('{KIND_COMPLETE, OP_READ_COMPUTE, 2'd2, 3'd0, 2'd1, 1'b0, 1'b0, 9'd4});
      queue_request('{KIND_ISSUE, OP_READ_COMPUTE, 2'd0, 3'd0, 2'd0, 1'b0, 1'b0, 9'd0});
      queue_request('{KIND_COMPLETE, OP_READ_COMPUTE, 2'd0, 3'd0, 2'd0, 1'b0, 1'b0, 9'd0});
      wait_drained();

      // random durations with idling on both sides
      load_durations(DUR_W'($urandom_range(1, 20'hFFFFF)), DUR_W'($urandom_range(1, 20'hFFFFF)),
                     DUR_W'($urandom_range(1, 20'hFFFFF)), DUR_W'($urandom_range(1, 20'hFFFFF)),
                     DUR_W'($urandom_range(1, 20'hFFFFF)));
      queue_random_traffic(300);
      wait_drained();

      // largest durations, no idling, long response hold so the block backs up
      idling = 1'b0;
      load_durations(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
      queue_random_traffic(250);
      hold_requests++;
      wait_drained();

      // smallest durations, zero among them
      idling = 1'b1;
      load_durations(20'd1, 20'd0, 20'd1, 20'd1, 20'd0);
      queue_random_traffic(250);
      wait_drained();

      // closing stretch without idling
      idling = 1'b0;
      load_durations(DUR_W'($urandom_range(1, 20'hFFFFF)), DUR_W'($urandom_range(1, 20'hFFFFF)),
                     DUR_W'($urandom_range(1, 20'hFFFFF)), DUR_W'($urandom_range(1, 20'hFFFFF)),
                     DUR_W'($urandom_range(1, 20'hFFFFF)));
      queue_random_traffic(300);
      wait_drained();

      if (error_count == 0)
         $display("flash_resource_scoreboard test passed");
      else
         $display("flash_resource_scoreboard test failed");
      $finish;
   end

endmodule
